// ===== rtl/gspi_pkg.sv =====
// Shared package for the gamepad SPI init-and-poll sequencer.
// Holds payload structs, the frame enum, protocol constants and lookup functions.
// No dependencies.
`default_nettype none

package gspi_pkg;

    // Frame kinds, in report encoding
    typedef enum logic [2:0] {
        FR_ENTER  = 3'd0,
        FR_ANALOG = 3'd1,
        FR_MOTOR  = 3'd2,
        FR_PRESS  = 3'd3,
        FR_EXIT   = 3'd4,
        FR_POLL   = 3'd5
    } t_frame;

    // Item modes
    localparam logic MODE_START    = 1'b0;
    localparam logic MODE_EXCHANGE = 1'b1;

    // Protocol bytes
    localparam logic [7:0] POLL_ID_PRESSURE = 8'h9E;
    localparam logic [7:0] ENTER_ACK        = 8'h5A;
    localparam logic [7:0] MOTOR_ECHO_SMALL = 8'h00;
    localparam logic [7:0] MOTOR_ECHO_LARGE = 8'h80;
    localparam logic [7:0] BUTTONS_XOR      = 8'h0F;
    localparam logic [4:0] BUTTONS_SLOT     = 5'd2;

    // Frame lengths and poll reply window
    localparam logic [4:0] LEN_SHORT   = 5'd5;
    localparam logic [4:0] LEN_CONFIG  = 5'd9;
    localparam logic [4:0] LEN_POLL    = 5'd21;
    localparam logic [4:0] POS_ID      = 5'd1;
    localparam logic [4:0] POS_ACK     = 5'd2;
    localparam logic [4:0] POS_SMALL   = 5'd3;
    localparam logic [4:0] POS_LARGE   = 5'd4;
    localparam logic [4:0] POS_REPORT0 = 5'd3;

    // Poll countdown codes
    localparam logic [1:0] POLLS_NONE = 2'd0;
    localparam logic [1:0] POLLS_ONE  = 2'd1;
    localparam logic [1:0] POLLS_ZERO_MOTOR = 2'd2;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
        logic [7:0] small_motor;
        logic [7:0] large_motor;
    } t_in_item;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic       select_active;
        logic       frame_done;
        logic [2:0] frame_kind;
        logic       report_write;
        logic [4:0] report_index;
        logic [7:0] report_value;
        logic       motor_boost;
        logic       link_ready;
    } t_out_item;

    // Number of bytes in a frame
    function automatic logic [4:0] frame_len(input t_frame kind);
        logic [4:0] len;
        unique case (kind)
            FR_ENTER: len = LEN_SHORT;
            FR_POLL:  len = LEN_POLL;
            default:  len = LEN_CONFIG;
        endcase
        return len;
    endfunction

    // Command byte for a position within a frame
    function automatic logic [7:0] cmd_byte(input t_frame kind, input logic [4:0] pos,
                                            input logic [7:0] sm, input logic [7:0] lg);
        logic [7:0] b;
        b = 8'h00;
        if (pos == 5'd0) begin
            b = 8'h80;
        end else if (pos == 5'd1) begin
            unique case (kind)
                FR_ENTER:  b = 8'hC2;
                FR_ANALOG: b = 8'h22;
                FR_MOTOR:  b = 8'hB2;
                FR_PRESS:  b = 8'hF2;
                FR_EXIT:   b = 8'hC2;
                FR_POLL:   b = 8'h42;
                default:   b = 8'h00;
            endcase
        end else begin
            unique case (kind)
                FR_ENTER:  b = (pos == 5'd3) ? 8'h80 : 8'h00;
                FR_ANALOG: begin
                    if (pos == 5'd3) b = 8'h80;
                    else if (pos == 5'd4) b = 8'hC0;
                end
                FR_MOTOR: begin
                    if (pos == 5'd4) b = 8'h80;
                    else if (pos >= 5'd5 && pos <= 5'd8) b = 8'hFF;
                end
                FR_PRESS: begin
                    if (pos == 5'd3 || pos == 5'd4) b = 8'hFF;
                    else if (pos == 5'd5) b = 8'hC0;
                end
                FR_EXIT:   b = (pos >= 5'd4 && pos <= 5'd8) ? 8'h5A : 8'h00;
                // small motor sent as 255 * value mod 256, i.e. negated
                FR_POLL: begin
                    if (pos == POS_SMALL) b = 8'(~sm + 8'd1);
                    else if (pos == POS_LARGE) b = lg;
                end
                default:   b = 8'h00;
            endcase
        end
        return b;
    endfunction

    // Report slot for poll reply positions 3..20 (offset from position 3)
    function automatic logic [4:0] report_slot(input logic [4:0] ofs);
        logic [4:0] s;
        unique case (ofs)
            5'd0:    s = 5'd2;
            5'd1:    s = 5'd3;
            5'd2:    s = 5'd8;
            5'd3:    s = 5'd9;
            5'd4:    s = 5'd6;
            5'd5:    s = 5'd7;
            5'd6:    s = 5'd15;
            5'd7:    s = 5'd17;
            5'd8:    s = 5'd14;
            5'd9:    s = 5'd16;
            5'd10:   s = 5'd22;
            5'd11:   s = 5'd23;
            5'd12:   s = 5'd24;
            5'd13:   s = 5'd25;
            5'd14:   s = 5'd20;
            5'd15:   s = 5'd21;
            5'd16:   s = 5'd18;
            5'd17:   s = 5'd19;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    // Reply bytes arrive LSB first
    function automatic logic [7:0] bit_rev(input logic [7:0] b);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = b[7 - i];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/gamepad_spi_init_and_poll_sequencer.sv =====
// Top level of the gamepad SPI init-and-poll sequencer.
// Frame sequencing, command byte generation and poll reply translation.
// Depends on gspi_pkg.
//
// Channel  Direction  Handshake                 Payload
// in       input      i_in_valid / o_in_stall   i_in_data  (t_in_item)
// out      output     o_out_valid / i_out_stall o_out_data (t_out_item)
//
// Every accepted item produces exactly one result, registered for the cycle after accept.
// Throughput is one item per cycle while the output is not stalled; the sequencer state registers update at accept.
// The single output register is the only buffer: input stalls only while it is
// full and the downstream side stalls.
// Synchronous active-low reset returns to the config entry frame with no frame open.
`default_nettype none

module gamepad_spi_init_and_poll_sequencer (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  wire gspi_pkg::t_in_item i_in_data,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output gspi_pkg::t_out_item  o_out_data
);
    import gspi_pkg::*;

    // Sequencer state
    t_frame      r_frame,      n_frame;
    logic [4:0]  r_pos,        n_pos;
    logic        r_in_frame,   n_in_frame;
    logic [7:0]  r_poll_id,    n_poll_id;
    logic [7:0]  r_enter_reply, n_enter_reply;
    logic [7:0]  r_small_echo, n_small_echo;
    logic [7:0]  r_large_echo, n_large_echo;
    logic        r_confirm,    n_confirm;
    logic [1:0]  r_polls,      n_polls;

    // Result register
    logic        r_out_valid;
    t_out_item   r_out,        n_out;

    logic        accept;
    logic        exch;
    logic        zero_motor;
    logic [7:0]  sm, lg;
    logic [4:0]  nxt;
    logic        last_byte;
    logic        in_report;
    logic [1:0]  polls_dec;

    assign o_in_stall  = r_out_valid & i_out_stall;
    assign accept      = i_in_valid & ~o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Shared decode
    assign exch       = (i_in_data.mode == MODE_EXCHANGE) & r_in_frame;
    assign zero_motor = (r_frame == FR_POLL) && (r_polls == POLLS_ZERO_MOTOR);
    assign sm         = zero_motor ? 8'h00 : i_in_data.small_motor;
    assign lg         = zero_motor ? 8'h00 : i_in_data.large_motor;
    assign nxt        = r_pos + 5'd1;
    assign last_byte  = (nxt >= frame_len(r_frame));
    assign in_report  = (r_frame == FR_POLL) && (r_pos >= POS_REPORT0) && (r_pos < LEN_POLL);
    assign polls_dec  = (r_polls != POLLS_NONE) ? r_polls - 2'd1 : POLLS_NONE;

    // Next state
    always_comb begin
        n_frame       = r_frame;
        n_pos         = r_pos;
        n_in_frame    = r_in_frame;
        n_poll_id     = r_poll_id;
        n_enter_reply = r_enter_reply;
        n_small_echo  = r_small_echo;
        n_large_echo  = r_large_echo;
        n_confirm     = r_confirm;
        n_polls       = r_polls;
        if (i_in_data.mode == MODE_START) begin
            n_in_frame = 1'b1;
            n_pos      = 5'd0;
        end else if (r_in_frame) begin
            // capture replies checked at frame end
            if (r_frame == FR_ENTER && r_pos == POS_ACK)   n_enter_reply = i_in_data.rx_byte;
            if (r_frame == FR_MOTOR && r_pos == POS_SMALL) n_small_echo  = i_in_data.rx_byte;
            if (r_frame == FR_MOTOR && r_pos == POS_LARGE) n_large_echo  = i_in_data.rx_byte;
            if (r_frame == FR_POLL  && r_pos == POS_ID)    n_poll_id     = i_in_data.rx_byte;
            if (!last_byte) begin
                n_pos = nxt;
            end else begin
                n_in_frame = 1'b0;
                n_pos      = 5'd0;
                // frame order
                unique case (r_frame)
                    FR_ENTER: begin
                        if (r_enter_reply == ENTER_ACK) begin
                            n_frame = FR_ANALOG;
                        end else begin
                            n_frame = FR_POLL;
                            n_polls = POLLS_ONE;
                        end
                    end
                    FR_ANALOG: n_frame = FR_MOTOR;
                    FR_MOTOR: begin
                        if (r_confirm) begin
                            n_confirm = 1'b0;
                            n_frame   = FR_PRESS;
                        end else begin
                            n_frame = FR_MOTOR;
                            if (r_small_echo == MOTOR_ECHO_SMALL &&
                                r_large_echo == MOTOR_ECHO_LARGE) begin
                                n_confirm = 1'b1;
                            end
                        end
                    end
                    FR_PRESS: n_frame = FR_EXIT;
                    FR_EXIT: begin
                        n_frame = FR_POLL;
                        n_polls = POLLS_ZERO_MOTOR;
                    end
                    FR_POLL: begin
                        if (polls_dec != POLLS_NONE) begin
                            n_frame = FR_POLL;
                            n_polls = polls_dec;
                        end else if (r_poll_id == POLL_ID_PRESSURE) begin
                            n_frame = FR_POLL;
                            n_polls = POLLS_ONE;
                        end else begin
                            n_frame = FR_ENTER;
                            n_polls = POLLS_NONE;
                        end
                    end
                    default: n_frame = FR_ENTER;
                endcase
            end
        end
    end

    // Result item
    always_comb begin
        n_out              = '0;
        n_out.frame_kind   = r_frame;
        n_out.link_ready   = (n_poll_id == POLL_ID_PRESSURE);
        if (i_in_data.mode == MODE_START) begin
            n_out.tx_byte       = cmd_byte(r_frame, 5'd0, sm, lg);
            n_out.tx_valid      = 1'b1;
            n_out.select_active = 1'b1;
        end else if (r_in_frame) begin
            if (!last_byte) begin
                n_out.tx_byte       = cmd_byte(r_frame, nxt, sm, lg);
                n_out.tx_valid      = 1'b1;
                n_out.select_active = 1'b1;
            end else begin
                n_out.frame_done = 1'b1;
            end
            if (in_report) begin
                n_out.report_write = 1'b1;
                n_out.report_index = report_slot(r_pos - POS_REPORT0);
                n_out.report_value = bit_rev(i_in_data.rx_byte) ^
                    ((report_slot(r_pos - POS_REPORT0) == BUTTONS_SLOT) ? BUTTONS_XOR : 8'h00);
            end
        end
        n_out.motor_boost = (r_frame == FR_POLL) &&
                            ((i_in_data.mode == MODE_START) || exch) &&
                            ((sm | lg) == 8'h00);
    end

    // State and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame       <= FR_ENTER;
            r_pos         <= 5'd0;
            r_in_frame    <= 1'b0;
            r_poll_id     <= 8'h00;
            r_enter_reply <= 8'h00;
            r_small_echo  <= 8'h00;
            r_large_echo  <= 8'h00;
            r_confirm     <= 1'b0;
            r_polls       <= POLLS_NONE;
            r_out_valid   <= 1'b0;
        end else begin
            if (accept) begin
                r_frame       <= n_frame;
                r_pos         <= n_pos;
                r_in_frame    <= n_in_frame;
                r_poll_id     <= n_poll_id;
                r_enter_reply <= n_enter_reply;
                r_small_echo  <= n_small_echo;
                r_large_echo  <= n_large_echo;
                r_confirm     <= n_confirm;
                r_polls       <= n_polls;
                r_out_valid   <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/gspi_checker.sv =====
// Port-level checker for the gamepad SPI init-and-poll sequencer, with its bind.
// Depends on gspi_pkg and gamepad_spi_init_and_poll_sequencer.
`default_nettype none

module gspi_checker (
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  i_in_valid,
    input wire                  o_in_stall,
    input wire gspi_pkg::t_in_item  i_in_data,
    input wire                  o_out_valid,
    input wire                  i_out_stall,
    input wire gspi_pkg::t_out_item o_out_data
);
    import gspi_pkg::*;

    // Every accepted transaction shows a result on the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_out_valid)
        else $error("accepted transaction produced no result");

    // A stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

    // Select follows the need for another exchange, never alongside frame end
    a_select: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.select_active == o_out_data.tx_valid) &&
                        !(o_out_data.frame_done && o_out_data.tx_valid))
        else $error("select or frame end inconsistent");

    // Report writes only come from poll frames
    a_report_poll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.report_write) |->
            (o_out_data.frame_kind == FR_POLL))
        else $error("report write outside a poll frame");

endmodule

bind gamepad_spi_init_and_poll_sequencer gspi_checker u_gspi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire
